// ===== rtl/core/prtbc_pkg.sv =====
// ----------------------------------------------------------------------------
// prtbc_pkg
// Shared constants, codes and types of the pre-trigger ring and triple-buffer
// capture unit.
// ----------------------------------------------------------------------------
package prtbc_pkg;

   localparam int RING_DEPTH   = 256;
   localparam int BUFFER_DEPTH = 512;
   localparam int NUM_BUFFERS  = 3;
   localparam int SAMPLE_BITS  = 12;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
   localparam int SEL_W        = 2;
   localparam int CAP_AW       = SEL_W + BUF_AW;
   localparam int FILL_W       = 10;
   localparam int COUNT_W      = 16;
   localparam int FLAG_W       = 4;
   localparam int DONE_BIT     = 3;
   localparam int OP_W         = 3;
   localparam int BANK_W       = 3;
   localparam int INDEX_W      = 9;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 40;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = 1;

   localparam logic [COUNT_W-1:0] CAPTURE_LENGTH_RESET = 16'd1250;

   localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd0;
   localparam logic [OP_W-1:0] OP_ARM_CLOSE = 3'd1;
   localparam logic [OP_W-1:0] OP_ARM_OPEN  = 3'd2;
   localparam logic [OP_W-1:0] OP_ACK       = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;

   localparam logic [BANK_W-1:0] BANK_RING_A = 3'd0;
   localparam logic [BANK_W-1:0] BANK_RING_B = 3'd1;
   localparam logic [BANK_W-1:0] BANK_BUF0   = 3'd2;
   localparam logic [BANK_W-1:0] BANK_BUF2   = 3'd4;

   typedef enum logic [2:0] {
      KIND_SAMPLE,
      KIND_ARM_CLOSE,
      KIND_ARM_OPEN,
      KIND_ACK,
      KIND_READ,
      KIND_STATUS
   } kind_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_RING_A,
      SRC_RING_B,
      SRC_CAPTURE
   } src_type;

   typedef struct packed {
      logic [INDEX_W-1:0]     read_index;
      logic [BANK_W-1:0]      read_bank;
      logic [FLAG_W-1:0]      ack_mask;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic [SAMPLE_BITS-1:0] sample_a;
   } req_fields_type;

   typedef struct packed {
      logic [1:0]             pad;
      logic [RING_AW-1:0]     ring_position;
      logic [FILL_W-1:0]      buffer_fill;
      logic [SEL_W-1:0]       active_buffer;
      logic                   capture_channel;
      logic                   capturing;
      logic [FLAG_W-1:0]      ready_flags;
      logic [SAMPLE_BITS-1:0] read_data;
   } result_type;

   typedef struct packed {
      kind_type               kind;
      logic [SAMPLE_BITS-1:0] sample_a;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic [FLAG_W-1:0]      ack_mask;
      src_type                src;
      logic [SEL_W-1:0]       cap_buf;
      logic [INDEX_W-1:0]     read_index;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/pretrigger_ring_triple_buffer_capture_unit.sv =====
// ----------------------------------------------------------------------------
// pretrigger_ring_triple_buffer_capture_unit
// Pre-trigger ring and triple-buffer capture of ADC sample pairs.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room and returns one
// response per request, in order. A request passes a two-entry queue and
// then the execution stage, which does the one memory write or read of that
// request and loads the response register. While responses are taken, the
// sustained rate of one request per cycle is set by the single write and
// read port of each ring and of the capture store. Ring entries read as zero
// until written, through a valid bit per slot, so no clearing pass follows
// reset; capture buffer entries read before being written are undefined.
// ----------------------------------------------------------------------------
module pretrigger_ring_triple_buffer_capture_unit import prtbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample_a, sample_b, ack_mask, read_bank, read_index
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_data, ready_flags, capturing, capture_channel, active_buffer,
   // buffer_fill, ring_position, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data
);

   queue_status_type q_stat;
   logic             q_push, q_pop;
   cmd_type          q_in_cmd, q_out_cmd;
   result_type       rsp_res;

   prtbc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd)
   );

   prtbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .pop_cmd  (q_out_cmd),
      .stat     (q_stat)
   );

   prtbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!q_stat.empty),
      .cmd         (q_out_cmd),
      .cmd_pop     (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_res     (rsp_res),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   assign rsp_tdata = rsp_res;

`ifndef NO_ASSERTIONS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("command popped from empty queue");

   a_buffer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_res.active_buffer != SEL_W'(NUM_BUFFERS)))
      else $error("active buffer out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_res.buffer_fill} < (FILL_W+1)'(BUFFER_DEPTH)))
      else $error("buffer fill reached buffer depth");

   a_channel_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_res.capture_channel) |-> rsp_res.capturing)
      else $error("channel B selected while not capturing");
`endif

endmodule

// ===== rtl/core/prtbc_front.sv =====
// ----------------------------------------------------------------------------
// prtbc_front
// Request intake: decodes the opcode and the read bank into a command for
// the queue.
// ----------------------------------------------------------------------------
module prtbc_front import prtbc_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  queue_status_type      q_stat,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   req_fields_type       req;
   kind_type             kind;
   logic [BANK_W-1:0]    bank_off;
   logic                 ring_in_range;
   logic                 buf_in_range;

   assign req        = req_fields_type'(req_tdata);
   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      unique case (req_tuser)
         OP_SAMPLE:    kind = KIND_SAMPLE;
         OP_ARM_CLOSE: kind = KIND_ARM_CLOSE;
         OP_ARM_OPEN:  kind = KIND_ARM_OPEN;
         OP_ACK:       kind = KIND_ACK;
         OP_READ:      kind = KIND_READ;
         default:      kind = KIND_STATUS;
      endcase
   end

   assign bank_off      = req.read_bank - BANK_BUF0;
   assign ring_in_range = ({1'b0, req.read_index} < (INDEX_W+1)'(RING_DEPTH));
   assign buf_in_range  = ({1'b0, req.read_index} < (INDEX_W+1)'(BUFFER_DEPTH));

   always_comb begin
      q_cmd.kind       = kind;
      q_cmd.sample_a   = req.sample_a;
      q_cmd.sample_b   = req.sample_b;
      q_cmd.ack_mask   = req.ack_mask;
      q_cmd.cap_buf    = bank_off[SEL_W-1:0];
      q_cmd.read_index = req.read_index;
      priority if (kind != KIND_READ) begin
         q_cmd.src = SRC_ZERO;
      end else if (req.read_bank == BANK_RING_A && ring_in_range) begin
         q_cmd.src = SRC_RING_A;
      end else if (req.read_bank == BANK_RING_B && ring_in_range) begin
         q_cmd.src = SRC_RING_B;
      end else if (req.read_bank >= BANK_BUF0 && req.read_bank <= BANK_BUF2
                   && buf_in_range) begin
         q_cmd.src = SRC_CAPTURE;
      end else begin
         q_cmd.src = SRC_ZERO;
      end
   end

endmodule

// ===== rtl/core/prtbc_queue.sv =====
// ----------------------------------------------------------------------------
// prtbc_queue
// Short command queue between the request intake and the execution stage.
// ----------------------------------------------------------------------------
module prtbc_queue import prtbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type stat
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + (QUEUE_AW+1)'(1);
         2'b01:   cnt_in = cnt_ff - (QUEUE_AW+1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/prtbc_back.sv =====
// ----------------------------------------------------------------------------
// prtbc_back
// Execution stage: rings, capture store, capture control and the response
// register.
// ----------------------------------------------------------------------------
module prtbc_back import prtbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output result_type         rsp_res,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   logic [SAMPLE_BITS-1:0] ring_a_mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_b_mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] cap_mem    [NUM_BUFFERS*BUFFER_DEPTH];

   logic [RING_DEPTH-1:0]  ring_vld_ff;
   logic [RING_AW-1:0]     ring_ptr_ff, ring_ptr_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic [COUNT_W-1:0]     sample_cnt_ff, sample_cnt_in;
   logic [FLAG_W-1:0]      flags_ff, flags_in;
   logic                   arm_close_ff, arm_close_in;
   logic                   arm_open_ff, arm_open_in;
   logic [COUNT_W-1:0]     cap_len_ff;
   logic                   rsp_valid_ff;

   logic [SAMPLE_BITS-1:0] ring_a_rd_ff, ring_b_rd_ff, cap_rd_ff;
   logic                   ring_vld_rd_ff;
   src_type                src_ff;

   logic                   armed;
   logic                   ring_we, cap_we, rd_en;
   logic [RING_AW-1:0]     ring_rd_addr;
   logic [CAP_AW-1:0]      cap_wr_addr, cap_rd_addr;
   logic [SAMPLE_BITS-1:0] cap_wdata;
   logic [SAMPLE_BITS-1:0] read_data;

   assign armed        = arm_close_ff || arm_open_ff;
   assign cmd_pop      = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign ring_we      = cmd_pop && cmd.kind == KIND_SAMPLE && !armed;
   assign cap_we       = cmd_pop && cmd.kind == KIND_SAMPLE && armed;
   assign rd_en        = cmd_pop && cmd.kind == KIND_READ;
   assign ring_rd_addr = cmd.read_index[RING_AW-1:0];
   assign cap_wr_addr  = {sel_ff, fill_ff[BUF_AW-1:0]};
   assign cap_rd_addr  = {cmd.cap_buf, cmd.read_index[BUF_AW-1:0]};
   assign cap_wdata    = arm_close_ff ? cmd.sample_a : cmd.sample_b;

   // state update for the command leaving the queue
   always_comb begin
      ring_ptr_in   = ring_ptr_ff;
      fill_in       = fill_ff;
      sel_in        = sel_ff;
      sample_cnt_in = sample_cnt_ff;
      flags_in      = flags_ff;
      arm_close_in  = arm_close_ff;
      arm_open_in   = arm_open_ff;
      if (cmd_pop) begin
         unique case (cmd.kind)
            KIND_SAMPLE: begin
               if (!armed) begin
                  ring_ptr_in = ring_ptr_ff + RING_AW'(1);
               end else begin
                  if (fill_ff[BUF_AW-1:0] == BUF_AW'(BUFFER_DEPTH - 1)) begin
                     flags_in[sel_ff] = 1'b1;
                     sel_in  = (sel_ff == SEL_W'(NUM_BUFFERS - 1)) ? '0
                                                                   : sel_ff + SEL_W'(1);
                     fill_in = '0;
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  sample_cnt_in = sample_cnt_ff + COUNT_W'(1);
                  if (sample_cnt_in >= cap_len_ff) begin
                     sample_cnt_in      = '0;
                     arm_close_in       = 1'b0;
                     arm_open_in        = 1'b0;
                     flags_in[DONE_BIT] = 1'b1;
                  end
               end
            end
            KIND_ARM_CLOSE: arm_close_in = 1'b1;
            KIND_ARM_OPEN:  arm_open_in  = 1'b1;
            KIND_ACK: begin
               if (cmd.ack_mask[DONE_BIT] && flags_ff[DONE_BIT]) begin
                  fill_in = '0;
               end
               flags_in = flags_ff & ~cmd.ack_mask;
            end
            KIND_READ, KIND_STATUS: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff   <= '0;
         ring_ptr_ff   <= '0;
         fill_ff       <= '0;
         sel_ff        <= '0;
         sample_cnt_ff <= '0;
         flags_ff      <= '0;
         arm_close_ff  <= 1'b0;
         arm_open_ff   <= 1'b0;
         cap_len_ff    <= CAPTURE_LENGTH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ring_we) begin
            ring_vld_ff[ring_ptr_ff] <= 1'b1;
         end
         ring_ptr_ff   <= ring_ptr_in;
         fill_ff       <= fill_in;
         sel_ff        <= sel_in;
         sample_cnt_ff <= sample_cnt_in;
         flags_ff      <= flags_in;
         arm_close_ff  <= arm_close_in;
         arm_open_ff   <= arm_open_in;
         if (csr_wr_en) begin
            cap_len_ff <= csr_wr_data;
         end
         if (cmd_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ring memories
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_a_mem[ring_ptr_ff] <= cmd.sample_a;
         ring_b_mem[ring_ptr_ff] <= cmd.sample_b;
      end
      if (rd_en) begin
         ring_a_rd_ff   <= ring_a_mem[ring_rd_addr];
         ring_b_rd_ff   <= ring_b_mem[ring_rd_addr];
         ring_vld_rd_ff <= ring_vld_ff[ring_rd_addr];
      end
   end

   // capture store
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_wr_addr] <= cap_wdata;
      end
      if (rd_en) begin
         cap_rd_ff <= cap_mem[cap_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         src_ff <= cmd.src;
      end
   end

   always_comb begin
      unique case (src_ff)
         SRC_RING_A:  read_data = ring_vld_rd_ff ? ring_a_rd_ff : '0;
         SRC_RING_B:  read_data = ring_vld_rd_ff ? ring_b_rd_ff : '0;
         SRC_CAPTURE: read_data = cap_rd_ff;
         default:     read_data = '0;
      endcase
   end

   // status fields only change when the next command pops
   assign rsp_tvalid              = rsp_valid_ff;
   assign rsp_res.pad             = '0;
   assign rsp_res.ring_position   = ring_ptr_ff;
   assign rsp_res.buffer_fill     = fill_ff;
   assign rsp_res.active_buffer   = sel_ff;
   assign rsp_res.capture_channel = !arm_close_ff && arm_open_ff;
   assign rsp_res.capturing       = armed;
   assign rsp_res.ready_flags     = flags_ff;
   assign rsp_res.read_data       = read_data;

endmodule
